// ===== src/ffsa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared types and constants of the first-fit slot allocator: field widths,
// request and status codes, and register map of the configuration port.
// ----------------------------------------------------------------------------
package ffsa_pkg;

   // pool size default
   localparam int NUM_SLOTS_DEFAULT = 64;

   // fixed field widths
   localparam int SLOT_W       = 6;
   localparam int USED_COUNT_W = 7;
   localparam int GC_THRESH_W  = 7;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [CSR_IDX_W-1:0]   CSR_IDX_GC_LIMIT = CSR_IDX_W'(0);
   localparam logic [GC_THRESH_W-1:0] GC_LIMIT_RESET   = GC_THRESH_W'(64);

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OOM       = 2'd1,
      ST_NOT_ALLOC = 2'd2
   } status_type;

endpackage

// ===== src/ffsa_req_if.sv =====
// ----------------------------------------------------------------------------
// ffsa_req_if
// Request channel: valid/ready handshake carrying one allocate or free request.
// ----------------------------------------------------------------------------
interface ffsa_req_if import ffsa_pkg::*; ();

   logic              valid;
   logic              ready;
   op_type            operation;
   logic [SLOT_W-1:0] slot_to_free;

   modport source (output valid, output operation, output slot_to_free, input ready);
   modport sink   (input valid, input operation, input slot_to_free, output ready);

endinterface

// ===== src/ffsa_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ffsa_rsp_if
// Result channel: valid/ready handshake carrying one allocator result.
// ----------------------------------------------------------------------------
interface ffsa_rsp_if import ffsa_pkg::*; ();

   logic                    valid;
   logic                    ready;
   status_type              status;
   logic [SLOT_W-1:0]       granted_slot;
   logic [USED_COUNT_W-1:0] used_count;
   logic                    threshold_reached;

   modport source (output valid, output status, output granted_slot,
                   output used_count, output threshold_reached, input ready);
   modport sink   (input valid, input status, input granted_slot,
                   input used_count, input threshold_reached, output ready);

endinterface

// ===== src/first_fit_slot_allocator_core.sv =====
// Path: a request transfer is loaded into the input register, and its result then into the
//   result register, which presents it (input register, then result register).
// Throughput: 1 request per cycle unless a held result stalls; the bitmap lookup, update and
//   count step of one request sit between the input register and the result register.
// Reset: synchronous, active high; every slot free, count zero, threshold 64.
// ----------------------------------------------------------------------------
// first_fit_slot_allocator_core
// Fixed pool allocator: allocate grants the lowest free slot, free releases a
// named slot; each result carries status, used count and a threshold flag.
// ----------------------------------------------------------------------------
module first_fit_slot_allocator_core import ffsa_pkg::*; #(
   parameter int NUM_SLOTS = NUM_SLOTS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   ffsa_req_if.sink              req_chan,
   ffsa_rsp_if.source            rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W = $clog2(NUM_SLOTS + 1);
   localparam int CMP_W = (CNT_W > GC_THRESH_W) ? CNT_W : GC_THRESH_W;

   // ------------------------------------------------------------------
   // Configuration register
   // ------------------------------------------------------------------
   logic [GC_THRESH_W-1:0] gc_limit_ff, gc_limit_in;
   logic                   csr_write;
   logic [CSR_IDX_W-1:0]   csr_idx;

   assign pready    = 1'b1;
   assign csr_idx   = paddr[CSR_ADDR_W-1:2];
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      gc_limit_in = gc_limit_ff;
      if (csr_write && (csr_idx == CSR_IDX_GC_LIMIT)) begin
         gc_limit_in = pwdata[GC_THRESH_W-1:0];
      end
   end

   // read back; unmapped addresses read zero
   always_comb begin
      prdata = '0;
      if (csr_idx == CSR_IDX_GC_LIMIT) begin
         prdata = CSR_DATA_W'(gc_limit_ff);
      end
   end

   // ------------------------------------------------------------------
   // Input register
   // ------------------------------------------------------------------
   logic              in_valid_ff, in_valid_in;
   op_type            in_op_ff, in_op_in;
   logic [SLOT_W-1:0] in_slot_ff, in_slot_in;
   logic              advance;
   logic              req_take;

   // process the held request whenever the result register is free or draining
   assign advance        = in_valid_ff && (!rsp_chan.valid || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_op_in    = in_op_ff;
      in_slot_in  = in_slot_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
         in_op_in    = req_chan.operation;
         in_slot_in  = req_chan.slot_to_free;
      end
   end

   // ------------------------------------------------------------------
   // Allocator state and request evaluation
   // ------------------------------------------------------------------
   logic [NUM_SLOTS-1:0] slot_used_map_ff, slot_used_map_in;
   logic [CNT_W-1:0]     slots_in_use_ff, slots_in_use_in;

   logic                 alloc_found;
   logic [IDX_W-1:0]     alloc_idx;
   logic [IDX_W-1:0]     free_idx;
   logic                 free_in_range;
   logic                 free_hit;
   status_type           eval_status;
   logic [IDX_W-1:0]     eval_grant;

   ffsa_first_free #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_first_free (
      .used_map  (slot_used_map_ff),
      .found     (alloc_found),
      .first_idx (alloc_idx)
   );

   assign free_idx      = IDX_W'(in_slot_ff);
   // indexes past the pool count as never allocated
   assign free_in_range = (32'(in_slot_ff) < 32'(NUM_SLOTS));
   assign free_hit      = free_in_range && slot_used_map_ff[free_idx];

   always_comb begin
      slot_used_map_in = slot_used_map_ff;
      slots_in_use_in  = slots_in_use_ff;
      eval_status      = ST_OK;
      eval_grant       = '0;
      if (in_op_ff == OP_ALLOC) begin
         if (alloc_found) begin
            eval_grant = alloc_idx;
         end else begin
            eval_status = ST_OOM;
         end
      end else begin
         if (!free_hit) begin
            eval_status = ST_NOT_ALLOC;
         end
      end
      // commit only when the request moves into the result register
      if (advance && (eval_status == ST_OK)) begin
         if (in_op_ff == OP_ALLOC) begin
            slot_used_map_in = slot_used_map_ff | (NUM_SLOTS'(1) << alloc_idx);
            slots_in_use_in  = slots_in_use_ff + CNT_W'(1);
         end else begin
            slot_used_map_in = slot_used_map_ff & ~(NUM_SLOTS'(1) << free_idx);
            slots_in_use_in  = slots_in_use_ff - CNT_W'(1);
         end
      end
   end

   // ------------------------------------------------------------------
   // Result register
   // ------------------------------------------------------------------
   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]       rsp_grant_ff, rsp_grant_in;
   logic [USED_COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic                    rsp_thresh_ff, rsp_thresh_in;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_grant_in  = rsp_grant_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_thresh_in = rsp_thresh_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = eval_status;
         rsp_grant_in  = SLOT_W'(eval_grant);
         rsp_count_in  = USED_COUNT_W'(slots_in_use_in);
         rsp_thresh_in = (CMP_W'(slots_in_use_in) >= CMP_W'(gc_limit_ff));
      end
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.status            = rsp_status_ff;
   assign rsp_chan.granted_slot      = rsp_grant_ff;
   assign rsp_chan.used_count        = rsp_count_ff;
   assign rsp_chan.threshold_reached = rsp_thresh_ff;

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         gc_limit_ff      <= GC_LIMIT_RESET;
         in_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         slot_used_map_ff <= '0;
         slots_in_use_ff  <= '0;
      end else begin
         gc_limit_ff      <= gc_limit_in;
         in_valid_ff      <= in_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
         slot_used_map_ff <= slot_used_map_in;
         slots_in_use_ff  <= slots_in_use_in;
      end
   end

   // payload: no reset
   always_ff @(posedge clock) begin
      in_op_ff      <= in_op_in;
      in_slot_ff    <= in_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_grant_ff  <= rsp_grant_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_thresh_ff <= rsp_thresh_in;
   end

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
`ifndef SYNTH
   // count tracks the bitmap population
   a_count_matches_map: assert property (@(posedge clock) disable iff (reset)
      $countones(slot_used_map_ff) == 32'(slots_in_use_ff))
      else $error("slot count differs from bitmap population");

   // count never exceeds the pool
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      32'(slots_in_use_ff) <= 32'(NUM_SLOTS))
      else $error("slot count exceeds pool size");

   // out of memory only reported with a full pool
   a_oom_only_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == ST_OOM)) |-> (&slot_used_map_ff))
      else $error("out of memory reported with a free slot");
`endif

endmodule

// ===== src/ffsa_first_free.sv =====
// ----------------------------------------------------------------------------
// ffsa_first_free
// Priority encoder: lowest free slot of the used-slot bitmap.
// ----------------------------------------------------------------------------
module ffsa_first_free import ffsa_pkg::*; #(
   parameter int NUM_SLOTS = NUM_SLOTS_DEFAULT,
   localparam int IDX_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
   input  logic [NUM_SLOTS-1:0] used_map,
   output logic                 found,
   output logic [IDX_W-1:0]     first_idx
);

   logic [NUM_SLOTS-1:0] free_map;
   logic [NUM_SLOTS-1:0] lowest_onehot;

   // isolate the lowest set bit of the free map
   assign free_map      = ~used_map;
   assign lowest_onehot = free_map & (~free_map + NUM_SLOTS'(1));
   assign found         = |free_map;

   // one-hot to binary: OR of the indexes of set bits
   always_comb begin
      first_idx = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (lowest_onehot[i]) begin
            first_idx = first_idx | IDX_W'(i);
         end
      end
   end

endmodule
